// ===== hw/rtl/peu_pkg.sv =====
// ----------------------------------------------------------------------------
// peu_pkg
// Shared types, character constants and escape lookup for the entity decoder.
// ----------------------------------------------------------------------------
package peu_pkg;

  // Character codes
  localparam logic [7:0] CharAmp  = 8'h26;  // '&'
  localparam logic [7:0] CharSemi = 8'h3B;  // ';'
  localparam logic [7:0] CharDq   = 8'h22;  // '"'
  localparam logic [7:0] CharStar = 8'h2A;  // '*'
  localparam logic [7:0] CharCol  = 8'h3A;  // ':'
  localparam logic [7:0] CharLt   = 8'h3C;  // '<'
  localparam logic [7:0] CharGt   = 8'h3E;  // '>'
  localparam logic [7:0] CharQm   = 8'h3F;  // '?'
  localparam logic [7:0] CharBar  = 8'h7C;  // '|'

  // Escape body letters
  localparam logic [7:0] LetB = 8'h62;
  localparam logic [7:0] LetC = 8'h63;
  localparam logic [7:0] LetG = 8'h67;
  localparam logic [7:0] LetL = 8'h6C;
  localparam logic [7:0] LetM = 8'h6D;
  localparam logic [7:0] LetQ = 8'h71;
  localparam logic [7:0] LetS = 8'h73;
  localparam logic [7:0] LetT = 8'h74;
  localparam logic [7:0] LetV = 8'h76;

  // Up to four output bytes produced by one input byte
  localparam int unsigned MaxBytes = 4;

  // Decoded work for the back end: bytes in order, index of last byte, end flag
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [1:0]               last;
    logic                     fin;
  } cmd_t;

  // True if the byte can open an escape body
  function automatic logic is_lead(input logic [7:0] b);
    is_lead = (b == LetQ) || (b == LetS) || (b == LetC) ||
              (b == LetL) || (b == LetG) || (b == LetV);
  endfunction

  // Decoded character for a two-letter body, zero when not an escape
  function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
    decode_pair = 8'h00;
    if (a == LetQ && b == LetT) decode_pair = CharDq;
    if (a == LetS && b == LetT) decode_pair = CharStar;
    if (a == LetC && b == LetL) decode_pair = CharCol;
    if (a == LetL && b == LetT) decode_pair = CharLt;
    if (a == LetG && b == LetT) decode_pair = CharGt;
    if (a == LetQ && b == LetM) decode_pair = CharQm;
    if (a == LetV && b == LetB) decode_pair = CharBar;
  endfunction

endpackage

// ===== hw/rtl/peu_front.sv =====
// ----------------------------------------------------------------------------
// peu_front
// Input classifier: tracks the escape prefix and turns each byte into a
// command of zero to four output bytes.
// ----------------------------------------------------------------------------
module peu_front import peu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,   // input transaction this cycle
  input  logic [7:0] byte_i,
  input  logic       final_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  // Hold level codes
  localparam logic [1:0] LvlNone = 2'd0;  // nothing held
  localparam logic [1:0] LvlAmp  = 2'd1;  // ampersand held
  localparam logic [1:0] LvlOne  = 2'd2;  // ampersand and one letter
  localparam logic [1:0] LvlTwo  = 2'd3;  // ampersand and two letters

  logic [1:0] lvl_q, lvl_d;
  logic [7:0] h0_q, h0_d;
  logic [7:0] h1_q, h1_d;

  logic [MaxBytes-1:0][7:0] ob;
  logic [2:0]               n;
  logic                     fresh_en;
  logic [7:0]               dec;

  // Next hold state and emitted bytes
  always_comb begin
    lvl_d    = lvl_q;
    h0_d     = h0_q;
    h1_d     = h1_q;
    ob       = '0;
    n        = 3'd0;
    fresh_en = 1'b0;
    dec      = decode_pair(h0_q, h1_q);

    unique case (lvl_q)
      LvlNone: begin
        fresh_en = 1'b1;
      end
      LvlAmp: begin
        if (is_lead(byte_i)) begin
          h0_d  = byte_i;
          lvl_d = LvlOne;
        end else begin
          ob[0]    = CharAmp;
          n        = 3'd1;
          fresh_en = 1'b1;
        end
      end
      LvlOne: begin
        if (decode_pair(h0_q, byte_i) != 8'h00) begin
          h1_d  = byte_i;
          lvl_d = LvlTwo;
        end else begin
          ob[0]    = CharAmp;
          ob[1]    = h0_q;
          n        = 3'd2;
          fresh_en = 1'b1;
        end
      end
      LvlTwo: begin
        if (byte_i == CharSemi && dec != 8'h00) begin
          ob[0] = dec;
          n     = 3'd1;
          lvl_d = LvlNone;
        end else begin
          ob[0]    = CharAmp;
          ob[1]    = h0_q;
          ob[2]    = h1_q;
          n        = 3'd3;
          fresh_en = 1'b1;
        end
      end
      default: begin
        fresh_en = 1'b1;
      end
    endcase

    // Byte taken afresh after a broken or empty prefix
    if (fresh_en) begin
      if (byte_i == CharAmp) begin
        lvl_d = LvlAmp;
      end else begin
        ob[n[1:0]] = byte_i;
        n          = n + 3'd1;
        lvl_d      = LvlNone;
      end
    end

    // Flush whatever is held at the end of the string
    if (final_i) begin
      if (lvl_d != LvlNone) begin
        ob[n[1:0]] = CharAmp;
        n          = n + 3'd1;
      end
      if (lvl_d == LvlOne || lvl_d == LvlTwo) begin
        ob[n[1:0]] = h0_d;
        n          = n + 3'd1;
      end
      if (lvl_d == LvlTwo) begin
        ob[n[1:0]] = h1_d;
        n          = n + 3'd1;
      end
      lvl_d = LvlNone;
    end
  end

  assign push_o      = accept_i && (n != 3'd0);
  assign cmd_o.bytes = ob;
  assign cmd_o.last  = 2'(n - 3'd1);
  assign cmd_o.fin   = final_i;

  // Hold level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= LvlNone;
    end else if (accept_i) begin
      lvl_q <= lvl_d;
    end
  end

  // Held letters, valid only at the levels that imply them
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      h0_q <= h0_d;
      h1_q <= h1_d;
    end
  end

endmodule

// ===== hw/rtl/peu_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// peu_cmd_fifo
// Small command queue between the classifier and the byte emitter.
// ----------------------------------------------------------------------------
module peu_cmd_fifo import peu_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrMax) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrMax) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/peu_back.sv =====
// ----------------------------------------------------------------------------
// peu_back
// Byte emitter: walks the head command into the output register one byte per
// cycle while the register is free or drained, and marks burst and string ends.
// ----------------------------------------------------------------------------
module peu_back import peu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] byte_o,
  output logic       burst_end_o,
  output logic       string_end_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       burst_q, string_q;
  logic       load, at_last;

  // Output register refills when empty or drained this cycle
  assign load    = !empty_i && (!valid_q || ready_i);
  assign at_last = (idx_q == cmd_i.last);
  assign pop_o   = load && at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= at_last ? 2'd0 : idx_q + 2'd1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= cmd_i.bytes[idx_q];
      burst_q  <= at_last;
      string_q <= at_last && cmd_i.fin;
    end
  end

  assign valid_o      = valid_q;
  assign byte_o       = byte_q;
  assign burst_end_o  = burst_q;
  assign string_end_o = string_q;

endmodule

// ===== hw/rtl/path_entity_unescape_unit.sv =====
// ----------------------------------------------------------------------------
// path_entity_unescape_unit
// Streaming decoder that replaces four-byte path escapes by their characters.
// ----------------------------------------------------------------------------
// A byte's results pass through the command queue, then the output register.
// Throughput: one input byte per cycle while the queue has room; results leave
//   one per cycle while the sink is ready, holding the emitter until the last.
// The command queue (FifoDepth entries) absorbs bursts between the two sides.
// Reset clears the hold level, the queue and the output valid at once.
module path_entity_unescape_unit import peu_pkg::*; #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_final
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // burst_end
  output logic       m_axis_tlast    // string_end
);

  logic accept, push, full, pop, empty;
  cmd_t cmd_in, cmd_head;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  peu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .final_i  (s_axis_tlast),
    .push_o   (push),
    .cmd_o    (cmd_in)
  );

  peu_cmd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (cmd_head),
    .empty_o (empty)
  );

  peu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_head),
    .empty_i      (empty),
    .pop_o        (pop),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .byte_o       (m_axis_tdata),
    .burst_end_o  (m_axis_tuser),
    .string_end_o (m_axis_tlast)
  );

endmodule

// ===== tb/peu_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// peu_checker
// Watches both stream channels of the entity decoder. Every accepted input
// byte is decoded by a local model of the escape scanner, and the characters
// it should produce are queued. Every accepted output transaction is checked
// against the oldest queued character, field by field.
// ----------------------------------------------------------------------------
module peu_checker import peu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  logic       s_tready_i,
  input  logic [7:0] s_tdata_i,   // [7:0] in_byte
  input  logic       s_tlast_i,   // in_final
  input  logic       m_tvalid_i,
  input  logic       m_tready_i,
  input  logic [7:0] m_tdata_i,   // [7:0] out_byte
  input  logic       m_tuser_i,   // burst_end
  input  logic       m_tlast_i,   // string_end
  output int         errors_o,
  output int         pending_o,
  output int         results_o,
  output int         decoded_o
);

  // Scanner hold levels
  localparam logic [1:0] HoldNone = 2'd0;  // nothing held
  localparam logic [1:0] HoldAmp  = 2'd1;  // ampersand held
  localparam logic [1:0] HoldOne  = 2'd2;  // ampersand and one letter
  localparam logic [1:0] HoldTwo  = 2'd3;  // ampersand and two letters

  typedef struct {
    logic [7:0] ch;
    logic       burst_end;
    logic       string_end;
  } out_char_t;

  out_char_t  expected_chars [$];
  logic [1:0] hold_lvl;
  logic [7:0] held [2];

  // Letters that may open an escape body
  function automatic logic starts_escape(input logic [7:0] b);
    case (b)
      LetQ, LetS, LetC, LetL, LetG, LetV: starts_escape = 1'b1;
      default:                            starts_escape = 1'b0;
    endcase
  endfunction

  // Character for a two-letter body, zero when the pair is no escape
  function automatic logic [7:0] char_for_pair(input logic [7:0] a, input logic [7:0] b);
    case ({a, b})
      {LetQ, LetT}: char_for_pair = CharDq;
      {LetS, LetT}: char_for_pair = CharStar;
      {LetC, LetL}: char_for_pair = CharCol;
      {LetL, LetT}: char_for_pair = CharLt;
      {LetG, LetT}: char_for_pair = CharGt;
      {LetQ, LetM}: char_for_pair = CharQm;
      {LetV, LetB}: char_for_pair = CharBar;
      default:      char_for_pair = 8'h00;
    endcase
  endfunction

  // Advance the scanner by one byte and queue the characters it releases
  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] seq [$];
    logic [7:0] d;
    logic       restart;
    out_char_t  c;
    restart = 1'b0;
    case (hold_lvl)
      HoldNone: restart = 1'b1;
      HoldAmp: begin
        if (starts_escape(b)) begin
          held[0]  = b;
          hold_lvl = HoldOne;
        end else begin
          seq.push_back(CharAmp);
          restart = 1'b1;
        end
      end
      HoldOne: begin
        if (char_for_pair(held[0], b) != 8'h00) begin
          held[1]  = b;
          hold_lvl = HoldTwo;
        end else begin
          seq.push_back(CharAmp);
          seq.push_back(held[0]);
          restart = 1'b1;
        end
      end
      default: begin
        d = char_for_pair(held[0], held[1]);
        if (b == CharSemi && d != 8'h00) begin
          seq.push_back(d);
          hold_lvl = HoldNone;
          decoded_o++;
        end else begin
          seq.push_back(CharAmp);
          seq.push_back(held[0]);
          seq.push_back(held[1]);
          restart = 1'b1;
        end
      end
    endcase
    // A broken sequence re-scans the new byte from scratch
    if (restart) begin
      if (b == CharAmp) begin
        hold_lvl = HoldAmp;
      end else begin
        hold_lvl = HoldNone;
        seq.push_back(b);
      end
    end
    // End of string flushes whatever is held
    if (fin) begin
      if (hold_lvl >= HoldAmp) seq.push_back(CharAmp);
      if (hold_lvl >= HoldOne) seq.push_back(held[0]);
      if (hold_lvl >= HoldTwo) seq.push_back(held[1]);
      hold_lvl = HoldNone;
    end
    foreach (seq[i]) begin
      c.ch         = seq[i];
      c.burst_end  = (i == seq.size() - 1);
      c.string_end = (i == seq.size() - 1) && fin;
      expected_chars.push_back(c);
    end
  endtask

  // Monitor: inputs are predicted before outputs are compared
  always @(posedge clk_i or negedge rst_ni) begin
    out_char_t e;
    if (!rst_ni) begin
      hold_lvl = HoldNone;
      expected_chars.delete();
      errors_o  = 0;
      results_o = 0;
      decoded_o = 0;
      pending_o = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) decode_byte(s_tdata_i, s_tlast_i);
      if (m_tvalid_i && m_tready_i) begin
        results_o++;
        if (expected_chars.size() == 0) begin
          $error("unexpected output transaction: out_byte %02h", m_tdata_i);
          errors_o++;
        end else begin
          e = expected_chars.pop_front();
          if (m_tdata_i !== e.ch) begin
            $error("out_byte: expected %02h, got %02h", e.ch, m_tdata_i);
            errors_o++;
          end
          if (m_tuser_i !== e.burst_end) begin
            $error("burst_end: expected %0b, got %0b", e.burst_end, m_tuser_i);
            errors_o++;
          end
          if (m_tlast_i !== e.string_end) begin
            $error("string_end: expected %0b, got %0b", e.string_end, m_tlast_i);
            errors_o++;
          end
        end
      end
      pending_o = expected_chars.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the path entity decoder. A short directed string
// set covers each hold level, broken escapes and end-of-string flushes; then
// random strings mix complete escapes, broken prefixes and arbitrary bytes,
// with random gaps on the input side and random back-pressure on the output.
// ----------------------------------------------------------------------------
module tb_top import peu_pkg::*;;

  localparam int TotalItems = 456;   // directed part plus about 430 random bytes
  // Longest correct quiet stretch is a random input gap plus the decoder latency,
  // or a random output stall; the limit is far above either.
  localparam int IdleLimit  = 2000;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
  logic       s_axis_tlast  = 1'b0;    // in_final
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;            // [7:0] out_byte
  logic       m_axis_tuser;            // burst_end
  logic       m_axis_tlast;            // string_end

  int errors, pending, results, decoded;
  int sent    = 0;
  int strings = 0;
  bit tx_quiet = 1'b0;

  // Escape bodies, index-matched
  logic [7:0] esc_lead [7] = '{LetQ, LetS, LetC, LetL, LetG, LetQ, LetV};
  logic [7:0] esc_tail [7] = '{LetT, LetT, LetL, LetT, LetT, LetM, LetB};

  always #5 clk_i = ~clk_i;

  path_entity_unescape_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  peu_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .m_tlast_i  (m_axis_tlast),
    .errors_o   (errors),
    .pending_o  (pending),
    .results_o  (results),
    .decoded_o  (decoded)
  );

  // One input transaction after a random gap; valid stays high on a zero gap
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    if (fin) strings++;
    if (sent % 30 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_str(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && (i == s.len() - 1));
  endtask

  // Bytes that interact with the scanner more than random ones do
  function automatic logic [7:0] scanner_byte();
    case ($urandom_range(0, 3))
      0:       scanner_byte = CharAmp;
      1:       scanner_byte = CharSemi;
      2:       scanner_byte = esc_lead[$urandom_range(0, 6)];
      default: scanner_byte = esc_tail[$urandom_range(0, 6)];
    endcase
  endfunction

  // Output side: random stall before each transaction
  initial begin : sink
    int  gap;
    int  taken;
    bit  rx_quiet;
    taken = 0;
    rx_quiet = 1'b0;
    @(posedge clk_i);
    forever begin
      if (taken % 32 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      gap = rx_quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  // Watchdog on cycles without any transaction
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] chunk [$];
    int         k, r, n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero and all-ones bytes, broken one- and two-letter holds, flush at every hold level
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_str("&qt;", 1'b0);
    send_str("&q&", 1'b0);    // ampersand breaks a one-letter hold
    send_str("cl;", 1'b0);    // and starts a fresh escape
    send_str("&gtx", 1'b0);   // wrong terminator
    send_str("&", 1'b1);      // flush at each hold level
    send_str("&v", 1'b1);
    send_str("&lt", 1'b1);
    send_str("&qm;", 1'b1);   // escape completed by the final byte

    // Random: mostly complete escapes, then broken prefixes and plain bytes
    while (sent < TotalItems - 1) begin
      k = $urandom_range(0, 6);
      r = $urandom_range(0, 99);
      chunk.delete();
      if (r < 55) begin
        chunk = '{CharAmp, esc_lead[k], esc_tail[k], CharSemi};
      end else if (r < 78) begin
        chunk.push_back(CharAmp);
        n = $urandom_range(0, 2);
        if (n > 0) chunk.push_back(esc_lead[k]);
        if (n > 1) chunk.push_back(esc_tail[k]);
        chunk.push_back($urandom_range(0, 1) ? scanner_byte() : 8'($urandom_range(0, 255)));
      end else begin
        chunk.push_back(8'($urandom_range(0, 255)));
      end
      foreach (chunk[i]) send_byte(chunk[i], $urandom_range(0, 11) == 0);
    end
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    s_axis_tvalid <= 1'b0;

    // Let the checker see the last input transaction, then drain
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d input bytes in %0d strings, %0d output bytes, %0d escapes decoded.",
             sent, strings, results, decoded);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
